@@ rtl/alm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package alm_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int MODE_W   = 3;
  localparam int STATUS_W = 2;
  localparam int ID_W     = 64;
  localparam int NAME_W   = 64;
  localparam int GRADE_W  = 16;
  localparam int POS_W    = 4;

  localparam int IN_FIELDS_W  = POS_W + ID_W + NAME_W + GRADE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4 + 5 + 4 + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [MODE_W-1:0] MODE_ADD_FIRST = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD_AFTER = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ADD_LAST  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEL_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_DEL_AFTER = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DEL_LAST  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CLEAR_ALL = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

  typedef struct packed {
    logic              last;
    logic [SLOT_W-1:0] next;
  } link_t;

  typedef struct packed {
    logic [GRADE_W-1:0] grade;
    logic [NAME_W-1:0]  name_word;
    logic [ID_W-1:0]    id_code;
  } rec_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
  } rec_wr_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    count;
    logic [SLOT_W-1:0]   head;
    logic                list_empty;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/array_linked_list_manager.sv @@
// Singly linked list of records kept in a fixed slot array.
// Input stream (s_*): one transaction per operation; s_tuser carries the
// operation mode, s_tdata the position and the record (id, name, grade).
// Output stream (m_*): exactly one result transaction per operation; m_tuser
// carries the status, m_tdata the slot touched, record count, head slot and
// empty flag after the operation.
// One operation is in work at a time; s_tready is high only while idle.
// Path to result valid: add first, clear all, add last to an empty list and
// checks that fail at once go from dispatch to done; delete first unlinks
// the head; delete after reads the next link and unlinks that record (bad
// position if the position is the last record); add after writes the new
// link, then the link at the position; add last and delete last walk 1 to
// 16 records from the head, one link memory read per cycle, then link or
// unlink the tail. The next operation waits until the result is registered.
// The result sits in an output register; a new operation is accepted while
// it waits, but the next result holds the block until the register drains.
// When m_tready stays low, the held result and its payload stay stable.
// Reset empties the list: every slot free, count 0, head 0, empty flag set.
// No clearing pass runs; the block is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none

module array_linked_list_manager (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              s_tvalid,
  output logic                                   s_tready,
  // position, id_code, name_word, grade, zero fill
  input  wire logic [alm_pkg::IN_TDATA_W-1:0]    s_tdata,
  // mode
  input  wire logic [alm_pkg::MODE_W-1:0]        s_tuser,
  output logic                                   m_tvalid,
  input  wire logic                              m_tready,
  // slot, count, head, list_empty, zero fill
  output logic [alm_pkg::OUT_TDATA_W-1:0]        m_tdata,
  // status
  output logic [alm_pkg::STATUS_W-1:0]           m_tuser
);
  import alm_pkg::*;

  logic              in_accept;
  rec_t              rec_in;
  rec_t              rec_hold;
  rec_wr_t           rec_wr;
  rec_t              rec_mem [CAPACITY];
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  assign in_accept = s_tvalid && s_tready;
  assign res_ready = !m_tvalid || m_tready;

  always_comb begin
    rec_in.id_code   = s_tdata[POS_W +: ID_W];
    rec_in.name_word = s_tdata[POS_W + ID_W +: NAME_W];
    rec_in.grade     = s_tdata[POS_W + ID_W + NAME_W +: GRADE_W];
  end

  alm_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_mode   (s_tuser),
    .in_pos    (s_tdata[POS_W-1:0]),
    .rec_wr    (rec_wr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (in_accept) begin
      rec_hold <= rec_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_wr.we) begin
      rec_mem[rec_wr.addr] <= rec_hold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tuser <= res.status;
      m_tdata <= OUT_TDATA_W'({res.list_empty, res.head, res.count, res.slot});
    end
  end

endmodule

`default_nettype wire

@@ rtl/alm_free_find.sv @@
`timescale 1ns / 1ps
`default_nettype none

module alm_free_find (
  input  wire logic [alm_pkg::CAPACITY-1:0] used,
  output logic [alm_pkg::SLOT_W-1:0]        free_slot
);
  import alm_pkg::*;

  always_comb begin
    free_slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_slot = SLOT_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/alm_seq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module alm_seq (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [alm_pkg::MODE_W-1:0]   in_mode,
  input  wire logic [alm_pkg::POS_W-1:0]    in_pos,
  output alm_pkg::rec_wr_t                  rec_wr,
  output logic                              res_valid,
  input  wire logic                         res_ready,
  output alm_pkg::result_t                  res
);
  import alm_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_AA_WR1   = 4'd2;
  localparam logic [3:0] S_AA_WR2   = 4'd3;
  localparam logic [3:0] S_DA1      = 4'd4;
  localparam logic [3:0] S_DA2      = 4'd5;
  localparam logic [3:0] S_WALK     = 4'd6;
  localparam logic [3:0] S_AL_WR1   = 4'd7;
  localparam logic [3:0] S_AL_WR2   = 4'd8;
  localparam logic [3:0] S_DL       = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0]          state;
  logic [MODE_W-1:0]   mode;
  logic [SLOT_W-1:0]   pos;
  logic [SLOT_W-1:0]   cur;
  logic [SLOT_W-1:0]   prev;
  logic [SLOT_W-1:0]   n;
  logic [SLOT_W-1:0]   slot;
  logic [STATUS_W-1:0] status;
  logic [CAPACITY-1:0] used;
  logic [CNT_W-1:0]    count;
  logic [SLOT_W-1:0]   head;
  logic                empty;

  link_t               link_mem [CAPACITY];
  link_t               rd_data;
  logic                rd_en;
  logic [SLOT_W-1:0]   rd_addr;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;
  link_t               wr_data;

  logic [SLOT_W-1:0]   free_slot;
  logic                full;
  logic [CNT_W-1:0]    count_dec;
  logic                pos_used;
  logic                walk_end;

  alm_free_find u_free_find (
    .used      (used),
    .free_slot (free_slot)
  );

  assign full      = (count == CNT_W'(CAPACITY));
  assign count_dec = count - CNT_W'(1);
  assign pos_used  = used[pos];
  assign walk_end  = (n == SLOT_W'(CAPACITY - 1));

  assign in_ready  = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    res.status     = status;
    res.slot       = slot;
    res.count      = count;
    res.head       = empty ? '0 : head;
    res.list_empty = empty;
  end

  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = head;
    wr_en       = 1'b0;
    wr_addr     = free_slot;
    wr_data     = '0;
    rec_wr.we   = 1'b0;
    rec_wr.addr = free_slot;
    case (state)
      S_DISPATCH: begin
        case (mode)
          MODE_ADD_FIRST: begin
            if (!full) begin
              wr_en        = 1'b1;
              wr_data.last = empty;
              wr_data.next = empty ? '0 : head;
              rec_wr.we    = 1'b1;
            end
          end
          MODE_ADD_AFTER: begin
            if (!full && pos_used) begin
              rd_en   = 1'b1;
              rd_addr = pos;
            end
          end
          MODE_ADD_LAST: begin
            if (!full) begin
              if (empty) begin
                wr_en        = 1'b1;
                wr_data.last = 1'b1;
                rec_wr.we    = 1'b1;
              end else begin
                rd_en = 1'b1;
              end
            end
          end
          MODE_DEL_FIRST, MODE_DEL_LAST: begin
            rd_en = !empty;
          end
          MODE_DEL_AFTER: begin
            if (!empty && pos_used) begin
              rd_en   = 1'b1;
              rd_addr = pos;
            end
          end
          default: begin
          end
        endcase
      end
      S_AA_WR1: begin
        wr_en     = 1'b1;
        wr_data   = rd_data;
        rec_wr.we = 1'b1;
      end
      S_AA_WR2: begin
        wr_en        = 1'b1;
        wr_addr      = pos;
        wr_data.next = slot;
      end
      S_DA1: begin
        rd_en   = !rd_data.last;
        rd_addr = rd_data.next;
      end
      S_DA2: begin
        wr_en   = (mode == MODE_DEL_AFTER);
        wr_addr = pos;
        wr_data = rd_data;
      end
      S_WALK: begin
        rd_en   = !rd_data.last && !walk_end;
        rd_addr = rd_data.next;
      end
      S_AL_WR1: begin
        wr_en        = 1'b1;
        wr_data.last = 1'b1;
        rec_wr.we    = 1'b1;
      end
      S_AL_WR2: begin
        wr_en        = 1'b1;
        wr_addr      = cur;
        wr_data.next = slot;
      end
      S_DL: begin
        wr_en        = (cur != head);
        wr_addr      = prev;
        wr_data.last = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      count <= '0;
      head  <= '0;
      empty <= 1'b1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode   <= in_mode;
            pos    <= in_pos;
            status <= ST_OK;
            slot   <= '0;
            state  <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          state <= S_DONE;
          cur   <= head;
          prev  <= head;
          n     <= '0;
          case (mode)
            MODE_ADD_FIRST: begin
              if (full) begin
                status <= ST_FULL;
              end else begin
                used[free_slot] <= 1'b1;
                count           <= count + CNT_W'(1);
                empty           <= 1'b0;
                head            <= free_slot;
                slot            <= free_slot;
              end
            end
            MODE_ADD_AFTER: begin
              if (full) begin
                status <= ST_FULL;
              end else if (!pos_used) begin
                status <= ST_BAD_POS;
              end else begin
                state <= S_AA_WR1;
              end
            end
            MODE_ADD_LAST: begin
              if (full) begin
                status <= ST_FULL;
              end else if (empty) begin
                used[free_slot] <= 1'b1;
                count           <= count + CNT_W'(1);
                empty           <= 1'b0;
                head            <= free_slot;
                slot            <= free_slot;
              end else begin
                state <= S_WALK;
              end
            end
            MODE_DEL_FIRST: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                state <= S_DA2;
              end
            end
            MODE_DEL_AFTER: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else if (!pos_used) begin
                status <= ST_BAD_POS;
              end else begin
                state <= S_DA1;
              end
            end
            MODE_DEL_LAST: begin
              if (empty) begin
                status <= ST_EMPTY;
              end else begin
                state <= S_WALK;
              end
            end
            MODE_CLEAR_ALL: begin
              used  <= '0;
              count <= '0;
              empty <= 1'b1;
              head  <= '0;
            end
            default: begin
            end
          endcase
        end
        S_AA_WR1: begin
          used[free_slot] <= 1'b1;
          count           <= count + CNT_W'(1);
          empty           <= 1'b0;
          slot            <= free_slot;
          state           <= S_AA_WR2;
        end
        S_AA_WR2: begin
          state <= S_DONE;
        end
        S_DA1: begin
          if (rd_data.last) begin
            status <= ST_BAD_POS;
            state  <= S_DONE;
          end else begin
            slot  <= rd_data.next;
            state <= S_DA2;
          end
        end
        S_DA2: begin
          if (mode == MODE_DEL_FIRST) begin
            slot       <= head;
            used[head] <= 1'b0;
            head       <= rd_data.last ? '0 : rd_data.next;
          end else begin
            used[slot] <= 1'b0;
          end
          count <= count_dec;
          if (count_dec == '0) begin
            empty <= 1'b1;
            head  <= '0;
          end
          state <= S_DONE;
        end
        S_WALK: begin
          if (rd_data.last) begin
            state <= (mode == MODE_ADD_LAST) ? S_AL_WR1 : S_DL;
          end else begin
            prev <= cur;
            cur  <= rd_data.next;
            n    <= n + SLOT_W'(1);
            if (walk_end) begin
              state <= (mode == MODE_ADD_LAST) ? S_AL_WR1 : S_DL;
            end
          end
        end
        S_AL_WR1: begin
          used[free_slot] <= 1'b1;
          count           <= count + CNT_W'(1);
          empty           <= 1'b0;
          slot            <= free_slot;
          state           <= S_AL_WR2;
        end
        S_AL_WR2: begin
          state <= S_DONE;
        end
        S_DL: begin
          used[cur] <= 1'b0;
          slot      <= cur;
          count     <= count_dec;
          if (count_dec == '0) begin
            empty <= 1'b1;
            head  <= '0;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
